>>> rtl/core/mssd_pkg.sv
// Shared types, constants and the sample conversion for the marker-synced deframer.
// No dependencies; imported by every module of the block.
`default_nettype none

package mssd_pkg;

  localparam int SAMPLES_PER_PACKET = 64;
  localparam int PAYLOAD_BYTES      = SAMPLES_PER_PACKET * 2;
  localparam int FRAME_BYTES        = PAYLOAD_BYTES + 2;
  localparam int POS_W              = $clog2(FRAME_BYTES);
  localparam int CNT_W              = (SAMPLES_PER_PACKET > 1) ? $clog2(SAMPLES_PER_PACKET) : 1;

  localparam int SAMPLE_W = 13;
  localparam int INDEX_W  = 6;
  localparam int OFFSET_W = 16;

  localparam logic [7:0]          MARKER_BYTE  = 8'hFF;
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = 16'd1449;
  localparam logic signed [16:0]  FULL_SCALE   = 17'sd2048;

  typedef enum logic [1:0] {
    ST_HUNT,
    ST_COLLECT,
    ST_DRAIN
  } deframe_state_t;

  // one stored sample: value plus clamp flag
  typedef struct packed {
    logic                       sat;
    logic signed [SAMPLE_W-1:0] value;
  } cell_data_t;

  // raw little-endian code minus offset, clamped to +/- full scale
  function automatic cell_data_t convert_sample(input logic [7:0] hi, input logic [7:0] lo,
                                                input logic [OFFSET_W-1:0] offset);
    logic signed [16:0] diff;
    cell_data_t         res;
    diff = $signed({1'b0, hi, lo}) - $signed({1'b0, offset});
    if (diff > FULL_SCALE) begin
      res.value = FULL_SCALE[SAMPLE_W-1:0];
      res.sat   = 1'b1;
    end else if (diff < -FULL_SCALE) begin
      res.value = 13'sh1800;
      res.sat   = 1'b1;
    end else begin
      res.value = diff[SAMPLE_W-1:0];
      res.sat   = 1'b0;
    end
    return res;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/mssd_cell.sv
// One storage cell of the sample chain: holds a sample and passes it on when shifted.
// Depends on mssd_pkg.
`default_nettype none

module mssd_cell
  import mssd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       shift,
  input  wire cell_data_t d,
  output cell_data_t      q
);

  always_ff @(posedge clk) begin
    if (shift) begin
      q <= d;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/mssd_chain.sv
// Row of sample cells; items enter at cell 0 and leave from the last cell.
// Depends on mssd_pkg and mssd_cell.
`default_nettype none

module mssd_chain
  import mssd_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       shift,
  input  wire cell_data_t head,
  output cell_data_t      tail
);

  cell_data_t link [SAMPLES_PER_PACKET+1];

  assign link[0] = head;

  for (genvar i = 0; i < SAMPLES_PER_PACKET; i++) begin : g_cell
    mssd_cell u_cell (
      .clk   (clk),
      .shift (shift),
      .d     (link[i]),
      .q     (link[i+1])
    );
  end

  assign tail = link[SAMPLES_PER_PACKET];

endmodule

`default_nettype wire

>>> rtl/core/marker_synced_sample_deframer.sv
// Top level of the marker-synced sample deframer: framing control, offset register,
// output register. Depends on mssd_pkg and mssd_chain.
//
// Usage:
//   s_axis carries received bytes (tdata[7:0]). After reset the block hunts for two
//   consecutive 0xFF bytes, then takes packets of 64 little-endian 16-bit codes and
//   two trailer bytes. Each code, minus sample_offset and clamped to +/-2048, shifts
//   into a row of 64 cells as its high byte arrives.
//   m_axis gives one sample per item: tdata[12:0] sample, [18:13] sample_index,
//   [19] saturated; tlast marks the last sample of the packet.
//   A good trailer (0xFF 0xFF) starts the drain: the state register enters the drain,
//   then the first sample is registered into the output register, then one per cycle
//   while m_axis_tready is high. s_axis_tready is low for the whole drain, so a packet
//   costs 130 accepted bytes plus the drain, which lasts until the cell row has shifted
//   all 64 samples out into the output register. Otherwise one byte is taken every cycle.
//   A bad trailer drops the packet silently and the block hunts again.
//   A stall on m_axis holds the output register; in the drain it also holds the row and input stays blocked.
//   Reset (rst, synchronous) returns to hunting with sample_offset = 1449.
//   The user writes sample_offset_we/wdata only while the block is idle; unchecked.
`default_nettype none

module marker_synced_sample_deframer
  import mssd_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                sample_offset_we,
  input  wire logic [OFFSET_W-1:0] sample_offset_wdata,
  input  wire logic                s_axis_tvalid,
  output logic                     s_axis_tready,
  input  wire logic [7:0]          s_axis_tdata,   // [7:0] rx_byte
  output logic                     m_axis_tvalid,
  input  wire logic                m_axis_tready,
  output logic [23:0]              m_axis_tdata,   // [12:0] sample, [18:13] sample_index,
                                                   // [19] saturated, [23:20] zero
  output logic                     m_axis_tlast    // last_of_packet
);

  deframe_state_t      state, state_next;
  logic [OFFSET_W-1:0] sample_offset;
  logic                prev_marker, prev_marker_next;
  logic [POS_W-1:0]    byte_pos, byte_pos_next;
  logic [7:0]          low_hold, low_hold_next;
  logic                trailer_ok, trailer_ok_next;
  logic [CNT_W-1:0]    drain_cnt, drain_cnt_next;
  logic [INDEX_W-1:0]  drain_idx, drain_idx_next;
  logic                out_valid, out_valid_next;

  logic                       in_acc;
  logic                       load;
  logic                       chain_shift;
  logic                       is_marker;
  logic                       drain_last;
  cell_data_t                 chain_head, chain_tail;
  logic signed [SAMPLE_W-1:0] out_sample;
  logic [INDEX_W-1:0]         out_index;
  logic                       out_sat;
  logic                       out_last;

  assign s_axis_tready = (state != ST_DRAIN);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign load          = !out_valid || m_axis_tready;
  assign is_marker     = (s_axis_tdata == MARKER_BYTE);
  assign drain_last    = (drain_cnt == CNT_W'(SAMPLES_PER_PACKET - 1));
  assign chain_head    = convert_sample(s_axis_tdata, low_hold, sample_offset);

  always_comb begin
    state_next       = state;
    prev_marker_next = prev_marker;
    byte_pos_next    = byte_pos;
    low_hold_next    = low_hold;
    trailer_ok_next  = trailer_ok;
    drain_cnt_next   = drain_cnt;
    drain_idx_next   = drain_idx;
    out_valid_next   = load ? 1'b0 : out_valid;
    chain_shift      = 1'b0;
    unique case (state)
      ST_HUNT: begin
        if (in_acc) begin
          if (prev_marker && is_marker) begin
            state_next       = ST_COLLECT;
            prev_marker_next = 1'b0;
            byte_pos_next    = '0;
            trailer_ok_next  = 1'b0;
          end else begin
            prev_marker_next = is_marker;
          end
        end
      end
      ST_COLLECT: begin
        if (in_acc) begin
          if (byte_pos < POS_W'(PAYLOAD_BYTES)) begin
            if (byte_pos[0]) begin
              chain_shift = 1'b1;
            end else begin
              low_hold_next = s_axis_tdata;
            end
            byte_pos_next = byte_pos + 1'b1;
          end else if (byte_pos == POS_W'(PAYLOAD_BYTES)) begin
            trailer_ok_next = is_marker;
            byte_pos_next   = byte_pos + 1'b1;
          end else begin
            byte_pos_next   = '0;
            trailer_ok_next = 1'b0;
            drain_cnt_next  = '0;
            drain_idx_next  = '0;
            // second trailer byte decides: drain or drop
            if (trailer_ok && is_marker) begin
              state_next = ST_DRAIN;
            end else begin
              state_next       = ST_HUNT;
              prev_marker_next = 1'b0;
            end
          end
        end
      end
      ST_DRAIN: begin
        if (load) begin
          chain_shift    = 1'b1;
          out_valid_next = 1'b1;
          drain_cnt_next = drain_cnt + 1'b1;
          drain_idx_next = drain_idx + 1'b1;
          if (drain_last) begin
            state_next = ST_COLLECT;
          end
        end
      end
      default: state_next = ST_HUNT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HUNT;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_offset <= OFFSET_RESET;
      prev_marker   <= 1'b0;
      byte_pos      <= '0;
      trailer_ok    <= 1'b0;
      drain_cnt     <= '0;
      drain_idx     <= '0;
      out_valid     <= 1'b0;
    end else begin
      if (sample_offset_we) begin
        sample_offset <= sample_offset_wdata;
      end
      prev_marker <= prev_marker_next;
      byte_pos    <= byte_pos_next;
      trailer_ok  <= trailer_ok_next;
      drain_cnt   <= drain_cnt_next;
      drain_idx   <= drain_idx_next;
      out_valid   <= out_valid_next;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    low_hold <= low_hold_next;
    if (state == ST_DRAIN && load) begin
      out_sample <= chain_tail.value;
      out_sat    <= chain_tail.sat;
      out_index  <= drain_idx;
      out_last   <= drain_last;
    end
  end

  mssd_chain u_chain (
    .clk   (clk),
    .shift (chain_shift),
    .head  (chain_head),
    .tail  (chain_tail)
  );

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {4'b0000, out_sat, out_index, out_sample};
  assign m_axis_tlast  = out_last;

endmodule

`default_nettype wire

>>> rtl/core/mssd_checker.sv
// Port-level checks for the marker-synced deframer, bound to the top level.
// Depends on mssd_pkg and marker_synced_sample_deframer.
`default_nettype none

module mssd_checker
  import mssd_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [23:0] m_axis_tdata,
  input wire logic        m_axis_tlast
);

  logic signed [SAMPLE_W-1:0] smp;
  logic [INDEX_W-1:0]         idx;
  logic                       sat;

  assign smp = $signed(m_axis_tdata[12:0]);
  assign idx = m_axis_tdata[18:13];
  assign sat = m_axis_tdata[19];

  // tlast sits on the final packet position
  a_last_index: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> idx == INDEX_W'(SAMPLES_PER_PACKET - 1))
    else $error("tlast on wrong sample index");

  // clamp flag only with a full-scale value
  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && sat |-> (smp == 13'sd2048 || smp == -13'sd2048))
    else $error("saturated flag without full-scale value");

  // drain is over once the last item is taken
  a_ready_after_last: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tready && m_axis_tlast |=> s_axis_tready)
    else $error("input still blocked after packet end");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tlast))
    else $error("output item changed while stalled");

endmodule

bind marker_synced_sample_deframer mssd_checker u_mssd_checker (.*);

`default_nettype wire

>>> verif/tb.sv
// Self-checking testbench for marker_synced_sample_deframer: byte frames in on s_axis, samples
// checked on m_axis against an in-bench deframing predictor, with random stalls on both sides.
// Depends on mssd_pkg and the RTL of the block; nothing else.
`default_nettype none

module tb;
  import mssd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int HOLD_CYCLES    = 300;
  localparam int DIR_ROWS       = 10;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] value;
    logic [INDEX_W-1:0]         idx;
    logic                       sat;
    logic                       is_last;
  } sample_rec_t;

  // one directed sample slot; exp_* are typed in only where the answer is obvious
  typedef struct packed {
    logic [15:0]                code;
    logic                       typed;
    logic signed [SAMPLE_W-1:0] exp_value;
    logic                       exp_sat;
  } slot_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                sample_offset_we = 1'b0;
  logic [OFFSET_W-1:0] sample_offset_wdata = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata = '0;   // [7:0] rx_byte
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [23:0]         m_axis_tdata;        // [12:0] sample, [18:13] sample_index,
                                            // [19] saturated, [23:20] zero
  logic                m_axis_tlast;        // last_of_packet

  marker_synced_sample_deframer dut (
    .clk                 (clk),
    .rst                 (rst),
    .sample_offset_we    (sample_offset_we),
    .sample_offset_wdata (sample_offset_wdata),
    .s_axis_tvalid       (s_axis_tvalid),
    .s_axis_tready       (s_axis_tready),
    .s_axis_tdata        (s_axis_tdata),
    .m_axis_tvalid       (m_axis_tvalid),
    .m_axis_tready       (m_axis_tready),
    .m_axis_tdata        (m_axis_tdata),
    .m_axis_tlast        (m_axis_tlast)
  );

  always #5 clk = ~clk;

  // predictor state
  logic                       pr_collecting = 1'b0;
  logic                       pr_prev_ff = 1'b0;
  int                         pr_pos = 0;
  logic [7:0]                 pr_low = '0;
  logic                       pr_trailer_ok = 1'b0;
  logic [OFFSET_W-1:0]        pr_offset = OFFSET_RESET;
  logic signed [SAMPLE_W-1:0] pr_value [SAMPLES_PER_PACKET];
  logic                       pr_sat [SAMPLES_PER_PACKET];

  sample_rec_t expected_samples [$];

  logic                       typed_mask [SAMPLES_PER_PACKET];
  logic signed [SAMPLE_W-1:0] typed_value [SAMPLES_PER_PACKET];
  logic                       typed_sat [SAMPLES_PER_PACKET];

  logic [15:0] frame_codes [SAMPLES_PER_PACKET];
  logic        calm = 1'b0;
  logic        held = 1'b0;
  int          errors = 0;
  int          samples_checked = 0;
  int          packets_good = 0;
  int          packets_dropped = 0;
  int          bytes_sent = 0;
  int          offset_writes = 0;
  int          idle_cycles = 0;

  // first slots of the packet sent at the reset offset
  slot_row_t dir_rows [DIR_ROWS] = '{
    '{16'd1449,  1'b1, 13'sd0,     1'b0},
    '{16'd0,     1'b1, -13'sd1449, 1'b0},
    '{16'hFFFF,  1'b1, 13'sd2048,  1'b1},
    '{16'd3497,  1'b1, 13'sd2048,  1'b0},
    '{16'd3498,  1'b1, 13'sd2048,  1'b1},
    '{16'd1448,  1'b1, -13'sd1,    1'b0},
    '{16'd1450,  1'b1, 13'sd1,     1'b0},
    '{16'h8000,  1'b1, 13'sd2048,  1'b1},
    '{16'd3000,  1'b0, 13'sd0,     1'b0},
    '{16'd4660,  1'b0, 13'sd0,     1'b0}
  };

  // predictor: one accepted byte in, a whole packet of expected samples out on a good trailer
  function automatic void deframe_byte(input logic [7:0] b);
    int          diff;
    logic [15:0] raw;
    sample_rec_t rec;
    if (!pr_collecting) begin
      if (pr_prev_ff && b == MARKER_BYTE) begin
        pr_collecting = 1'b1;
        pr_prev_ff    = 1'b0;
        pr_pos        = 0;
        pr_trailer_ok = 1'b0;
      end else begin
        pr_prev_ff = (b == MARKER_BYTE);
      end
    end else if (pr_pos < PAYLOAD_BYTES) begin
      if (pr_pos % 2 == 0) begin
        pr_low = b;
      end else begin
        raw  = {b, pr_low};
        diff = int'(raw) - int'(pr_offset);
        pr_sat[pr_pos / 2] = (diff > int'(FULL_SCALE)) || (diff < -int'(FULL_SCALE));
        if (diff > int'(FULL_SCALE)) diff = int'(FULL_SCALE);
        else if (diff < -int'(FULL_SCALE)) diff = -int'(FULL_SCALE);
        pr_value[pr_pos / 2] = diff[SAMPLE_W-1:0];
      end
      pr_pos++;
    end else if (pr_pos == PAYLOAD_BYTES) begin
      pr_trailer_ok = (b == MARKER_BYTE);
      pr_pos++;
    end else if (!(pr_trailer_ok && b == MARKER_BYTE)) begin
      // bad trailer: drop and hunt with an empty marker history
      pr_collecting = 1'b0;
      pr_prev_ff    = 1'b0;
      pr_pos        = 0;
      pr_low        = '0;
      pr_trailer_ok = 1'b0;
      packets_dropped++;
    end else begin
      for (int i = 0; i < SAMPLES_PER_PACKET; i++) begin
        rec.value   = typed_mask[i] ? typed_value[i] : pr_value[i];
        rec.sat     = typed_mask[i] ? typed_sat[i] : pr_sat[i];
        rec.idx     = INDEX_W'(i);
        rec.is_last = (i == SAMPLES_PER_PACKET - 1);
        expected_samples.push_back(rec);
      end
      pr_pos        = 0;
      pr_trailer_ok = 1'b0;
      packets_good++;
    end
  endfunction

  // acceptance on both sides, checking, watchdog
  always @(posedge clk) begin
    sample_rec_t want;
    logic        moved;
    if (!rst) begin
      moved = 1'b0;
      if (s_axis_tvalid && s_axis_tready) begin
        deframe_byte(s_axis_tdata);
        moved = 1'b1;
      end
      if (m_axis_tvalid && m_axis_tready) begin
        moved = 1'b1;
        if (expected_samples.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("[%0t] unexpected sample %0d index %0d sat %0b last %0b", $realtime,
                     $signed(m_axis_tdata[12:0]), m_axis_tdata[18:13], m_axis_tdata[19],
                     m_axis_tlast);
        end else begin
          want = expected_samples.pop_front();
          samples_checked++;
          if (m_axis_tdata[12:0] !== want.value || m_axis_tdata[18:13] !== want.idx ||
              m_axis_tdata[19] !== want.sat || m_axis_tlast !== want.is_last) begin
            errors++;
            if (errors <= 10) begin
              $display("[%0t] mismatch: exp %0d idx %0d sat %0b last %0b", $realtime,
                       want.value, want.idx, want.sat, want.is_last);
              $display("    got %0d idx %0d sat %0b last %0b",
                       $signed(m_axis_tdata[12:0]), m_axis_tdata[18:13], m_axis_tdata[19],
                       m_axis_tlast);
            end
          end
        end
      end
      idle_cycles = moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG_LIMIT);
        $display("marker_synced_sample_deframer test failed");
        $finish;
      end
    end
  end

  // receiver: random stall bursts, steady stretches, one long hold-off while a drain is pending
  initial begin
    int steady_left;
    steady_left = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      @(negedge clk);
      if (!held && !calm && packets_good >= 1 && expected_samples.size() != 0) begin
        held = 1'b1;
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        m_axis_tready <= 1'b1;
      end else if (!calm && steady_left == 0 && $urandom_range(0, 5) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        m_axis_tready <= 1'b1;
        if ($urandom_range(0, 2) == 0) steady_left = $urandom_range(20, 100);
      end else begin
        m_axis_tready <= 1'b1;
        if (steady_left > 0) steady_left--;
      end
    end
  end

  // all driver tasks start and end on a falling edge
  task automatic send_byte(input logic [7:0] b);
    if (!calm && $urandom_range(0, 7) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(negedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    bytes_sent++;
    @(negedge clk);
  endtask

  task automatic write_offset(input logic [OFFSET_W-1:0] v);
    s_axis_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    sample_offset_we    <= 1'b1;
    sample_offset_wdata <= v;
    @(negedge clk);
    sample_offset_we <= 1'b0;
    pr_offset = v;
    offset_writes++;
  endtask

  // marker only while hunting (optionally with a lone 0xFF broken by another byte first), then codes and trailer
  task automatic send_frame(input logic [7:0] tr0, input logic [7:0] tr1, input logic tricky);
    if (!pr_collecting) begin
      if (pr_prev_ff) send_byte(8'h5A);
      if (tricky) begin
        send_byte(MARKER_BYTE);
        send_byte(8'h3C);
      end
      send_byte(MARKER_BYTE);
      send_byte(MARKER_BYTE);
    end
    for (int i = 0; i < SAMPLES_PER_PACKET; i++) begin
      send_byte(frame_codes[i][7:0]);
      send_byte(frame_codes[i][15:8]);
    end
    send_byte(tr0);
    send_byte(tr1);
  endtask

  task automatic fill_random_codes();
    for (int i = 0; i < SAMPLES_PER_PACKET; i++) begin
      case ($urandom_range(0, 7))
        6: frame_codes[i] = 16'($urandom_range(0, 65535));
        7: begin
          case ($urandom_range(0, 5))
            0: frame_codes[i] = 16'h0000;
            1: frame_codes[i] = 16'hFFFF;
            2: frame_codes[i] = pr_offset + 16'd2048;
            3: frame_codes[i] = pr_offset + 16'd2049;
            4: frame_codes[i] = pr_offset - 16'd2048;
            default: frame_codes[i] = pr_offset - 16'd2049;
          endcase
        end
        default: frame_codes[i] = pr_offset + 16'($urandom_range(0, 4200)) - 16'd2100;
      endcase
    end
  endtask

  initial begin
    slot_row_t  row;
    logic [7:0] t0;
    logic [7:0] t1;
    for (int i = 0; i < SAMPLES_PER_PACKET; i++) typed_mask[i] = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed packet at the reset offset: table rows fill the first slots, a ramp the rest
    for (int i = 0; i < SAMPLES_PER_PACKET; i++)
      frame_codes[i] = OFFSET_RESET + 16'((i - 32) * 70);
    for (int r = 0; r < DIR_ROWS; r++) begin
      row = dir_rows[r];
      frame_codes[r] = row.code;
      typed_mask[r]  = row.typed;
      typed_value[r] = row.exp_value;
      typed_sat[r]   = row.exp_sat;
    end
    send_frame(MARKER_BYTE, MARKER_BYTE, 1'b1);
    for (int i = 0; i < SAMPLES_PER_PACKET; i++) typed_mask[i] = 1'b0;

    // random frame with a corrupted trailer, offered while the first drain is held off
    fill_random_codes();
    t0 = MARKER_BYTE;
    t1 = MARKER_BYTE;
    if ($urandom_range(0, 1) == 0) t0 = 8'($urandom_range(0, 254));
    else t1 = 8'($urandom_range(0, 254));
    send_frame(t0, t1, 1'b0);

    // closing stretch: new offset, one good random frame, no idling on either side
    write_offset(16'($urandom_range(2100, 63400)));
    calm = 1'b1;
    fill_random_codes();
    send_frame(MARKER_BYTE, MARKER_BYTE, $urandom_range(0, 1) == 1);

    s_axis_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(negedge clk);
    repeat (10) @(negedge clk);

    $display("run covered %0d bytes in, %0d packets emitted, %0d dropped on a bad trailer",
             bytes_sent, packets_good, packets_dropped);
    $display("%0d samples checked under %0d offset writes, %0d mismatches",
             samples_checked, offset_writes, errors);
    if (errors == 0 && expected_samples.size() == 0) begin
      $display("marker_synced_sample_deframer test passed");
    end else begin
      $display("marker_synced_sample_deframer test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
